// ===== hdl/ubs_pkg.sv =====
// ubs_pkg: shared types, constants and byte classification for the utf-8 byte sanitizer
// no dependencies

package ubs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 3;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned InDepth  = 2;
  localparam int unsigned OutDepth = 2;

  // register index codes (taken from paddr[2])
  localparam logic RegReplacement = 1'b0;

  localparam logic [ByteW-1:0] ReplReset = 8'h3F;

  localparam logic [ByteW-1:0] Mask1    = 8'h80;
  localparam logic [ByteW-1:0] Mask2    = 8'hE0;
  localparam logic [ByteW-1:0] Mask3    = 8'hF0;
  localparam logic [ByteW-1:0] Mask4    = 8'hF8;
  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] Lead4    = 8'hF0;
  localparam logic [ByteW-1:0] ContMask = 8'hC0;
  localparam logic [ByteW-1:0] ContVal  = 8'h80;

  // classified input word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic             cont;
    logic             last;
  } class_word_t;

  // result word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             repl;
    logic             run_last;
    logic             text_done;
  } result_word_t;

  function automatic logic [LenW-1:0] seq_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] l;
    l = 3'd0;
    if ((b & Mask1) == 8'h00) l = 3'd1;
    else if ((b & Mask2) == Lead2) l = 3'd2;
    else if ((b & Mask3) == Lead3) l = 3'd3;
    else if ((b & Mask4) == Lead4) l = 3'd4;
    return l;
  endfunction

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return (b & ContMask) == ContVal;
  endfunction

  // unfinished but so far good sequence of cnt bytes
  function automatic logic held_ok(input logic [LenW-1:0] lead_len, input logic c1,
                                   input logic c2, input logic [LenW-1:0] cnt);
    return (cnt != 3'd0) && (lead_len != 3'd0) && (cnt < lead_len) &&
           ((cnt < 3'd2) || c1) && ((cnt < 3'd3) || c2);
  endfunction

endpackage

// ===== hdl/ubs_front.sv =====
// ubs_front: input queue, classifies each byte on entry
// depends on ubs_pkg

module ubs_front
  import ubs_pkg::*;
#(
  parameter int unsigned DEPTH = InDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              end_of_text,
  output logic              full,
  input  logic              take,
  output logic              word_valid,
  output class_word_t       word
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  class_word_t         mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;
  class_word_t         in_word;

  assign full       = (count == CntW'(DEPTH));
  assign word_valid = (count != '0);
  assign word       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = take && word_valid;

  always_comb begin
    in_word.data = data_byte;
    in_word.len  = seq_len(data_byte);
    in_word.cont = is_cont(data_byte);
    in_word.last = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ubs_back.sv =====
// ubs_back: sequence buffer and resolver, one result per cycle unless holding or out_room is low
// depends on ubs_pkg

module ubs_back
  import ubs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  class_word_t       in_word,
  output logic              in_take,
  input  logic [ByteW-1:0]  repl_byte,
  input  logic              out_room,
  output logic              res_valid,
  output result_word_t      res_word
);

  logic [ByteW-1:0] hold_data [4];
  logic [LenW-1:0]  hold_len  [4];
  logic             hold_cont [4];
  logic [LenW-1:0]  hold_n;
  logic [1:0]       copy_rem;
  logic             endf;
  logic             busy;

  logic [ByteW-1:0] rem_data [4];
  logic [LenW-1:0]  rem_len  [4];
  logic             rem_cont [4];
  logic [LenW-1:0]  rem_n;

  logic [ByteW-1:0] base_data [4];
  logic [LenW-1:0]  base_len  [4];
  logic             base_cont [4];
  logic [LenW-1:0]  base_n;

  logic [ByteW-1:0] new_data [4];
  logic [LenW-1:0]  new_len  [4];
  logic             new_cont [4];
  logic [LenW-1:0]  new_n;
  logic             new_busy;

  logic             bad;
  logic             act_emit;
  logic             act_repl;
  logic [1:0]       copy_next;
  logic             emit;
  logic             last;
  logic             hold_case;
  logic [LenW-1:0]  len0;

  always_comb begin
    len0 = hold_len[0];
    bad  = (len0 == 3'd0) ||
           ((hold_n >= 3'd2) && (len0 >= 3'd2) && !hold_cont[1]) ||
           ((hold_n >= 3'd3) && (len0 >= 3'd3) && !hold_cont[2]) ||
           ((hold_n >= 3'd4) && (len0 >= 3'd4) && !hold_cont[3]);
    act_emit  = 1'b1;
    act_repl  = 1'b0;
    copy_next = 2'd0;
    if (copy_rem != 2'd0) begin
      copy_next = copy_rem - 2'd1;
    end else if (bad) begin
      act_repl = 1'b1;
    end else if (hold_n >= len0) begin
      copy_next = 2'(len0 - 3'd1);
    end else if (endf) begin
      act_repl = 1'b1;
    end else begin
      act_emit = 1'b0;
    end
  end

  // remainder after the front byte leaves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_data[i] = hold_data[i+1];
      rem_len[i]  = hold_len[i+1];
      rem_cont[i] = hold_cont[i+1];
    end
    rem_data[3] = hold_data[3];
    rem_len[3]  = hold_len[3];
    rem_cont[3] = hold_cont[3];
    rem_n = (hold_n == 3'd0) ? 3'd0 : hold_n - 3'd1;
  end

  assign emit      = busy && act_emit && out_room;
  assign hold_case = busy && !act_emit;
  assign last      = (rem_n == 3'd0) ||
                     ((copy_next == 2'd0) && !endf &&
                      held_ok(rem_len[0], rem_cont[1], rem_cont[2], rem_n));
  assign in_take   = in_valid && (!busy || (emit && last) || hold_case);

  // append the incoming byte
  always_comb begin
    if (emit) begin
      base_data = rem_data;
      base_len  = rem_len;
      base_cont = rem_cont;
      base_n    = rem_n;
    end else begin
      base_data = hold_data;
      base_len  = hold_len;
      base_cont = hold_cont;
      base_n    = hold_n;
    end
    for (int i = 0; i < 4; i++) begin
      if (base_n == 3'(i)) begin
        new_data[i] = in_word.data;
        new_len[i]  = in_word.len;
        new_cont[i] = in_word.cont;
      end else begin
        new_data[i] = base_data[i];
        new_len[i]  = base_len[i];
        new_cont[i] = base_cont[i];
      end
    end
    new_n    = base_n + 3'd1;
    new_busy = !(held_ok(new_len[0], new_cont[1], new_cont[2], new_n) && !in_word.last);
  end

  assign res_valid          = emit;
  assign res_word.data      = act_repl ? repl_byte : hold_data[0];
  assign res_word.repl      = act_repl;
  assign res_word.run_last  = last;
  assign res_word.text_done = last && endf;

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_data <= new_data;
      hold_len  <= new_len;
      hold_cont <= new_cont;
    end else if (emit) begin
      hold_data <= rem_data;
      hold_len  <= rem_len;
      hold_cont <= rem_cont;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_n   <= '0;
      copy_rem <= '0;
      endf     <= 1'b0;
      busy     <= 1'b0;
    end else if (in_take) begin
      hold_n   <= new_n;
      copy_rem <= 2'd0;
      endf     <= in_word.last;
      busy     <= new_busy;
    end else if (emit) begin
      hold_n   <= rem_n;
      copy_rem <= copy_next;
      busy     <= !last;
      if (last) begin
        endf <= 1'b0;
      end
    end else if (hold_case) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== hdl/ubs_outq.sv =====
// ubs_outq: result queue in front of the pop side
// depends on ubs_pkg

module ubs_outq
  import ubs_pkg::*;
#(
  parameter int unsigned DEPTH = OutDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  result_word_t  wr_word,
  output logic          room,
  input  logic          pop,
  output logic          empty,
  output result_word_t  rd_word
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_word_t     mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_pop;

  assign room    = (count != CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_word = mem[rd_ptr];
  assign do_wr   = wr_en && room;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/utf8_byte_sanitizer.sv =====
// utf8_byte_sanitizer: top level, configuration register and the three parts
// depends on ubs_pkg, ubs_front, ubs_back, ubs_outq
//
// channel   handshake             payload
// input     push / full           data_byte, end_of_text
// result    empty / pop           out_byte, was_replaced, run_last, text_done
// config    psel/penable/pwrite   paddr, pwdata, prdata (replacement_byte at 0x0)
//
// the back end makes one result per cycle while the result queue has room; a plain byte is taken
// in the cycle of the previous word's last result, and its result passes through the input queue,
// the held-sequence buffer and the result queue on its way to the pop side; a byte held in an
// unfinished sequence is taken with no result, so the input queue fills under multi-byte text
// a word that undoes a held sequence bursts up to four results while the input waits
// synchronous active-high reset empties both queues and the held sequence

module utf8_byte_sanitizer
  import ubs_pkg::*;
#(
  parameter int unsigned IN_DEPTH  = InDepth,
  parameter int unsigned OUT_DEPTH = OutDepth
) (
  input  logic              clk,
  input  logic              rst,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              end_of_text,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [ByteW-1:0]  out_byte,
  output logic              was_replaced,
  output logic              run_last,
  output logic              text_done,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [ByteW-1:0] replacement_byte;
  logic             cfg_wr;

  class_word_t      front_word;
  logic             front_valid;
  logic             back_take;
  result_word_t     back_word;
  logic             back_valid;
  logic             q_room;
  result_word_t     q_word;

  // single register, decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_byte <= ReplReset;
    end else if (cfg_wr && (paddr[2] == RegReplacement)) begin
      replacement_byte <= pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegReplacement) begin
      prdata = {{(DataW-ByteW){1'b0}}, replacement_byte};
    end
  end

  // front: accept and classify each byte
  ubs_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .full        (full),
    .take        (back_take),
    .word_valid  (front_valid),
    .word        (front_word)
  );

  // back: hold unfinished sequences, copy or replace one byte a cycle while the result queue has room
  ubs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_word   (front_word),
    .in_take   (back_take),
    .repl_byte (replacement_byte),
    .out_room  (q_room),
    .res_valid (back_valid),
    .res_word  (back_word)
  );

  // result queue decouples the pop side
  ubs_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_valid),
    .wr_word (back_word),
    .room    (q_room),
    .pop     (pop),
    .empty   (empty),
    .rd_word (q_word)
  );

  assign out_byte     = q_word.data;
  assign was_replaced = q_word.repl;
  assign run_last     = q_word.run_last;
  assign text_done    = q_word.text_done;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for utf8_byte_sanitizer, byte in, byte out with bad leads replaced
// depends on ubs_pkg and the utf8_byte_sanitizer rtl
`timescale 1ns / 1ps

module tb;
  import ubs_pkg::*;

  typedef struct {
    logic [7:0] val;
    logic       eot;
  } raw_word_t;

  typedef struct {
    logic [7:0] val;
    logic       repl;
    logic       last;
    logic       done;
  } clean_word_t;

  localparam logic [AddrW-1:0] ReplAddr = {RegReplacement, 2'b00};
  localparam int PhaseWords = 60;
  localparam int SettleCycles = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [ByteW-1:0] data_byte = '0;
  logic             end_of_text = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             was_replaced;
  logic             run_last;
  logic             text_done;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // words waiting to be offered, and sanitised words still owed by the block
  raw_word_t   raw_q[$];
  clean_word_t clean_q[$];

  // shadow of the block's state
  logic [7:0] repl_r = ReplReset;
  logic [7:0] held_r [3];
  int         held_n = 0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_repl = 0;
  int n_settings = 1;

  utf8_byte_sanitizer uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .end_of_text(end_of_text),
    .empty(empty), .pop(pop), .out_byte(out_byte), .was_replaced(was_replaced),
    .run_last(run_last), .text_done(text_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sequence length from a lead byte, zero for an invalid lead
  function automatic int lead_len(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // one input byte through the shadow state; appends the words it releases
  function automatic void sanitize_byte(input logic [7:0] b, input logic eot);
    logic [7:0]  win [4];
    logic [7:0]  rb [4];
    logic        rr [4];
    int          n, pos, len, avail, lim, j, k;
    logic        bad;
    clean_word_t w;
    for (j = 0; j < held_n; j++) win[j] = held_r[j];
    win[held_n] = b;
    n = held_n + 1;
    held_n = 0;
    pos = 0;
    k = 0;
    while (pos < n) begin
      len = lead_len(win[pos]);
      avail = n - pos;
      lim = (avail < len) ? avail : len;
      bad = 1'b0;
      for (j = 1; j < lim; j++) begin
        if (win[pos + j][7:6] != 2'b10) bad = 1'b1;
      end
      if (len == 0 || bad) begin
        // bad lead or bad follower: replace the lead, look again from the next byte
        rb[k] = repl_r;
        rr[k] = 1'b1;
        k++;
        pos++;
      end else if (avail >= len) begin
        for (j = 0; j < len; j++) begin
          rb[k] = win[pos + j];
          rr[k] = 1'b0;
          k++;
        end
        pos += len;
      end else if (eot) begin
        // cut off by the end of the string
        rb[k] = repl_r;
        rr[k] = 1'b1;
        k++;
        pos++;
      end else begin
        // good so far but unfinished: keep it for the next byte
        for (j = 0; j < avail; j++) held_r[j] = win[pos + j];
        held_n = avail;
        pos = n;
      end
    end
    for (j = 0; j < k; j++) begin
      w.val  = rb[j];
      w.repl = rr[j];
      w.last = (j == k - 1);
      w.done = (j == k - 1) && eot;
      clean_q.insert(clean_q.size(), w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued words in bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    raw_word_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sanitize_byte(data_byte, end_of_text);
        n_in++;
      end
      if (push && full) begin
        // word not taken yet: hold it steady
      end else if (raw_q.size() > 0 && gap_left == 0 && burst_left > 0) begin
        nxt = raw_q.pop_front();
        push <= 1'b1;
        data_byte <= nxt.val;
        end_of_text <= nxt.eot;
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        push <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (burst_left == 0) begin
          // now and then a long burst, so stretches with no idling occur too
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: pops on a pattern picked anew at random at regular intervals, checks each word
  // ---------------------------------------------------------------------------
  int  mon_cycle = 0;
  int  pop_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    clean_word_t want;
    logic        take;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_out++;
        if (was_replaced) n_repl++;
        if (clean_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual byte %h repl %b",
                   $time, out_byte, was_replaced);
        end else begin
          want = clean_q.pop_front();
          if (out_byte !== want.val) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.val, out_byte);
          end
          if (was_replaced !== want.repl) begin
            errors++;
            $display("%0t: was_replaced expected %b actual %b", $time, want.repl,
                     was_replaced);
          end
          if (run_last !== want.last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.last, run_last);
          end
          if (text_done !== want.done) begin
            errors++;
            $display("%0t: text_done expected %b actual %b", $time, want.done, text_done);
          end
        end
      end
      mon_cycle++;
      if (mon_cycle % 50 == 0) pop_mode = $urandom_range(0, 3);
      // one long hold-off while plenty of words are still queued to send,
      // so that both queues fill and full is raised
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && n_in >= 200 && raw_q.size() >= 16) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      case (pop_mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 1) == 1);
        2:       take = (mon_cycle % 4 == 0);
        default: take = ($urandom_range(0, 3) != 0);
      endcase
      pop <= take && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_raw(input logic [7:0] b, input logic eot);
    raw_word_t w;
    w.val = b;
    w.eot = eot;
    raw_q.insert(raw_q.size(), w);
  endtask

  function automatic logic [7:0] lead_of(input int len);
    case (len)
      1:       return {1'b0, 7'($urandom)};
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  // one string of random characters, mostly well formed, marked at its last byte
  task automatic add_text(input int chars, inout int added);
    logic [7:0] t[$];
    int         i, kind, len, j, good;
    for (i = 0; i < chars; i++) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (kind < 78) begin
        t.insert(t.size(), lead_of(len));
        for (j = 1; j < len; j++) t.insert(t.size(), {2'b10, 6'($urandom)});
      end else if (kind < 88) begin
        // raw noise, stray followers and invalid leads among it
        t.insert(t.size(), 8'($urandom));
      end else if (kind < 94) begin
        // truncated sequence, possibly right at the end of the string
        len = $urandom_range(2, 4);
        good = $urandom_range(0, len - 2);
        t.insert(t.size(), lead_of(len));
        for (j = 0; j < good; j++) t.insert(t.size(), {2'b10, 6'($urandom)});
      end else begin
        // broken sequence: a non-follower where a follower belongs
        len = $urandom_range(2, 4);
        good = $urandom_range(0, len - 2);
        t.insert(t.size(), lead_of(len));
        for (j = 0; j < good; j++) t.insert(t.size(), {2'b10, 6'($urandom)});
        t.insert(t.size(),
                 $urandom_range(0, 1) ? {1'b0, 7'($urandom)} : {2'b11, 6'($urandom)});
      end
    end
    for (i = 0; i < t.size(); i++) add_raw(t[i], i == t.size() - 1);
    added += t.size();
  endtask

  // sampled on the falling edge so the driver's decisions are settled
  task automatic wait_drained;
    @(negedge clk);
    while (raw_q.size() > 0 || push || clean_q.size() > 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ReplAddr;
    pwdata <= {{(DataW - 8){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    repl_r = v;
  endtask

  task automatic reg_check;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ReplAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== repl_r) begin
      errors++;
      $display("%0t: replacement_byte readback expected %h actual %h", $time, repl_r,
               prdata[7:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence: directed strings, then random phases under several settings
  // ---------------------------------------------------------------------------
  initial begin
    int          ph, added;
    logic [7:0]  setting;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default replacement after reset
    reg_check();

    // extremes of the single-byte range
    add_raw(8'h00, 1'b0);
    add_raw(8'h7F, 1'b0);
    // complete two, three and four byte sequences
    add_raw(8'hC3, 1'b0); add_raw(8'hA9, 1'b0);
    add_raw(8'hE2, 1'b0); add_raw(8'h82, 1'b0); add_raw(8'hAC, 1'b0);
    add_raw(8'hF0, 1'b0); add_raw(8'h9F, 1'b0); add_raw(8'h98, 1'b0); add_raw(8'h80, 1'b0);
    // stray follower, invalid leads
    add_raw(8'h80, 1'b0);
    add_raw(8'hFF, 1'b0);
    add_raw(8'hF8, 1'b0);
    // bad follower caught early, right after the lead and after one good follower
    add_raw(8'hE2, 1'b0); add_raw(8'h41, 1'b0);
    add_raw(8'hF0, 1'b0); add_raw(8'h9F, 1'b0); add_raw(8'h41, 1'b0);
    // three held bytes undone by a fourth: four words from one byte
    add_raw(8'hF0, 1'b0); add_raw(8'h9F, 1'b0); add_raw(8'h98, 1'b0); add_raw(8'h41, 1'b0);
    // sequence cut off by the end of the string
    add_raw(8'hF0, 1'b0); add_raw(8'h9F, 1'b0); add_raw(8'h98, 1'b1);

    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       setting = 8'h00;
          2:       setting = 8'hFF;
          3:       setting = 8'($urandom);
          default: setting = ReplReset;
        endcase
        reg_write(setting);
        reg_check();
        n_settings++;
      end
      added = 0;
      while (added < PhaseWords / 2) add_text($urandom_range(1, 25), added);
      // sender waits here until every owed word has come out
      wait_drained();
      while (added < PhaseWords) add_text($urandom_range(1, 25), added);
      wait_drained();
      // every string ends marked, so nothing is held; let the pipeline settle
      repeat (SettleCycles) @(negedge clk);
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    if (clean_q.size() > 0) begin
      errors++;
      $display("%0t: %0d words expected but never seen, expected %h actual none", $time,
               clean_q.size(), clean_q[0].val);
    end

    $display("run: %0d bytes in, %0d bytes out, %0d replaced, %0d replacement settings",
             n_in, n_out, n_repl, n_settings);
    $display("run: long result stall and input back-pressure %s", hold_done ? "seen" : "missed");
    if (errors == 0) begin
      $display("utf8_byte_sanitizer: match");
    end else begin
      $display("utf8_byte_sanitizer: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("timeout with %0d words still owed", clean_q.size());
    $display("utf8_byte_sanitizer: mismatch");
    $finish;
  end

endmodule
